[rtl/segmented_murmur64a_hash_top_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the segmented MurmurHash64A block
// Concurrent assertion wrappers used by the checker file.
// ----------------------------------------------------------------------------
`ifndef SEGMENTED_MURMUR64A_HASH_TOP_MACROS_SVH
`define SEGMENTED_MURMUR64A_HASH_TOP_MACROS_SVH

// Property checked on every edge outside reset
`define SMH_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("%m: property violated");

// Property checked on every edge, reset included
`define SMH_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) (prop)) \
      else $error("%m: property violated");

`endif

[rtl/smh_pkg.sv]
// ----------------------------------------------------------------------------
// smh_pkg
// Types, constants and codes shared by the segmented MurmurHash64A block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package smh_pkg;

   // field widths
   localparam int unsigned DATA_W  = 64;
   localparam int unsigned LEN_W   = 32;
   localparam int unsigned CNT_W   = 4;
   localparam int unsigned SEED_W  = 32;
   localparam int unsigned HALF_W  = 32;
   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned WORD_BYTES = 8;

   // MurmurHash64A constants
   localparam logic [DATA_W-1:0] MUL_K   = 64'hc6a4a7935bd1e995;
   localparam int unsigned       SHIFT_R = 47;

   // command queue between front and back
   localparam int unsigned QDEPTH = 2;
   localparam int unsigned QPTR_W = 1;
   localparam int unsigned QCNT_W = 2;

   // data kind of one item
   typedef enum logic [1:0] {
      KIND_NONE = 2'd0,
      KIND_FULL = 2'd1,
      KIND_TAIL = 2'd2
   } kind_type;

   // classified command handed from front to back
   typedef struct packed {
      logic              start;
      logic [LEN_W-1:0]  total;
      logic [DATA_W-1:0] word;
      kind_type          kind;
      logic              fin;
      logic              emit;
   } cmd_type;

   // partial product selector of the multiplier
   typedef enum logic [1:0] {
      PART_LL = 2'd0,
      PART_HL = 2'd1,
      PART_LH = 2'd2
   } part_type;

   // multiplier request and response
   typedef struct packed {
      logic              go;
      logic [DATA_W-1:0] operand;
   } mul_req_type;

   typedef struct packed {
      logic              done;
      logic [DATA_W-1:0] product;
   } mul_rsp_type;

   // back-end sequencer states
   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_SEED  = 8'b0000_0010,
      ST_KMIX1 = 8'b0000_0100,
      ST_KMIX2 = 8'b0000_1000,
      ST_HMIX  = 8'b0001_0000,
      ST_TAIL  = 8'b0010_0000,
      ST_FIN   = 8'b0100_0000,
      ST_EMIT  = 8'b1000_0000
   } back_state_type;

endpackage

[rtl/smh_ifs.sv]
// ----------------------------------------------------------------------------
// smh interfaces
// Valid/ready channels for requests, responses and the seed register write.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface smh_req_if;
   logic                            valid;
   logic                            ready;
   logic                            message_start;
   logic [smh_pkg::LEN_W-1:0]       total_length;
   logic [smh_pkg::DATA_W-1:0]      data_word;
   logic [smh_pkg::CNT_W-1:0]       byte_count;
   logic                            segment_end;
   logic                            message_end;

   modport source (output valid, message_start, total_length, data_word, byte_count,
                   segment_end, message_end, input ready);
   modport sink   (input valid, message_start, total_length, data_word, byte_count,
                   segment_end, message_end, output ready);
endinterface

interface smh_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [smh_pkg::DATA_W-1:0] hash_value;

   modport source (output valid, hash_value, input ready);
   modport sink   (input valid, hash_value, output ready);
endinterface

interface smh_csr_if;
   logic                       valid;
   logic                       ready;
   logic [smh_pkg::SEED_W-1:0] seed;

   modport source (output valid, seed, input ready);
   modport sink   (input valid, seed, output ready);
endinterface

[rtl/segmented_murmur64a_hash_top.sv]
// ----------------------------------------------------------------------------
// segmented_murmur64a_hash_top
// MurmurHash64A over a message fed as segments of up to eight bytes per item.
// ----------------------------------------------------------------------------
// Each item runs through the back end as a chain of 64-bit multiplies: one
// for a message start, three for a full word, one for a tail and one for a
// segment finalization (0 to 5 per item), plus an emit step when it ends a
// message. All of them share the single 32x32 multiplier, which builds each
// product modulo 2^64 from three partial products and an accumulate step.
// A two-entry command queue lets the request side keep transferring items,
// while it has room, as the back end works and while a response waits.
`timescale 1ns / 1ps

module segmented_murmur64a_hash_top (
   input  logic      clock,
   input  logic      reset,
   smh_req_if.sink   req_bus,
   smh_rsp_if.source rsp_bus,
   smh_csr_if.sink   csr_bus
);

   logic [smh_pkg::SEED_W-1:0] seed_ff, seed_in;
   logic                       q_full;
   logic                       q_push;
   smh_pkg::cmd_type           q_cmd;
   logic                       q_valid;
   logic                       q_pop;
   smh_pkg::cmd_type           q_head;
   smh_pkg::mul_req_type       mreq;
   smh_pkg::mul_rsp_type       mrsp;

   // seed register, written on a csr transfer
   assign csr_bus.ready = 1'b1;
   assign seed_in = (csr_bus.valid && csr_bus.ready) ? csr_bus.seed : seed_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= '0;
      end else begin
         seed_ff <= seed_in;
      end
   end

   smh_front u_front (
      .req    (req_bus),
      .q_full (q_full),
      .q_push (q_push),
      .q_cmd  (q_cmd)
   );

   smh_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_cmd  (q_cmd),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_valid),
      .head      (q_head)
   );

   smh_mul u_mul (
      .clock (clock),
      .reset (reset),
      .req   (mreq),
      .rsp   (mrsp)
   );

   smh_back u_back (
      .clock   (clock),
      .reset   (reset),
      .seed    (seed_ff),
      .q_valid (q_valid),
      .q_head  (q_head),
      .q_pop   (q_pop),
      .mreq    (mreq),
      .mrsp    (mrsp),
      .rsp     (rsp_bus)
   );

endmodule

[rtl/smh_front.sv]
// ----------------------------------------------------------------------------
// smh_front
// Accepts request items and classifies them into back-end commands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module smh_front (
   smh_req_if.sink          req,
   input  logic             q_full,
   output logic             q_push,
   output smh_pkg::cmd_type q_cmd
);

   logic [smh_pkg::DATA_W-1:0] tail_word;

   // take an item whenever the queue has room
   assign req.ready = !q_full;
   assign q_push    = req.valid && !q_full;

   // keep only the counted bytes of a tail
   always_comb begin
      tail_word = '0;
      for (int unsigned i = 0; i < smh_pkg::WORD_BYTES; i++) begin
         if (smh_pkg::CNT_W'(i) < req.byte_count) begin
            tail_word[i*smh_pkg::BYTE_W +: smh_pkg::BYTE_W] =
               req.data_word[i*smh_pkg::BYTE_W +: smh_pkg::BYTE_W];
         end
      end
   end

   // classify: counts of eight and above are full words
   always_comb begin
      q_cmd.start = req.message_start;
      q_cmd.total = req.total_length;
      q_cmd.emit  = req.message_end;
      priority if (req.byte_count >= smh_pkg::CNT_W'(smh_pkg::WORD_BYTES)) begin
         q_cmd.kind = smh_pkg::KIND_FULL;
         q_cmd.word = req.data_word;
      end else if (req.byte_count != '0) begin
         q_cmd.kind = smh_pkg::KIND_TAIL;
         q_cmd.word = tail_word;
      end else begin
         q_cmd.kind = smh_pkg::KIND_NONE;
         q_cmd.word = '0;
      end
      // a tail always closes its segment
      q_cmd.fin = req.segment_end || (q_cmd.kind == smh_pkg::KIND_TAIL);
   end

endmodule

[rtl/smh_fifo.sv]
// ----------------------------------------------------------------------------
// smh_fifo
// Short command queue that decouples the front from the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module smh_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  smh_pkg::cmd_type push_cmd,
   output logic             full,
   input  logic             pop,
   output logic             not_empty,
   output smh_pkg::cmd_type head
);

   smh_pkg::cmd_type                entries_ff [smh_pkg::QDEPTH];
   logic [smh_pkg::QPTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [smh_pkg::QPTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [smh_pkg::QCNT_W-1:0]      count_ff, count_in;

   assign full      = (count_ff == smh_pkg::QCNT_W'(smh_pkg::QDEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = entries_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == smh_pkg::QPTR_W'(smh_pkg::QDEPTH - 1)) ? '0
                     : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == smh_pkg::QPTR_W'(smh_pkg::QDEPTH - 1)) ? '0
                     : rd_ptr_ff + 1'b1;
      end
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage, no reset
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

[rtl/smh_mul.sv]
// ----------------------------------------------------------------------------
// smh_mul
// 64-bit multiply by the hash constant, modulo 2^64, from three 32x32
// partial products on one shared multiplier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module smh_mul (
   input  logic                 clock,
   input  logic                 reset,
   input  smh_pkg::mul_req_type req,
   output smh_pkg::mul_rsp_type rsp
);

   logic [smh_pkg::DATA_W-1:0] a_ff, a_in;
   logic                       busy_ff, busy_in;
   smh_pkg::part_type          part_ff, part_in;
   logic [smh_pkg::DATA_W-1:0] prod_ff, prod_in;
   logic                       pvld_ff, pvld_in;
   logic                       pfirst_ff, pfirst_in;
   logic                       plast_ff, plast_in;
   logic [smh_pkg::DATA_W-1:0] acc_ff, acc_in;
   logic                       done_ff, done_in;
   logic [smh_pkg::HALF_W-1:0] a_sel, b_sel;
   logic [smh_pkg::DATA_W-1:0] full_prod;

   // operand halves for the current partial product
   always_comb begin
      a_sel = (part_ff == smh_pkg::PART_HL) ? a_ff[smh_pkg::DATA_W-1:smh_pkg::HALF_W]
                                            : a_ff[smh_pkg::HALF_W-1:0];
      b_sel = (part_ff == smh_pkg::PART_LH) ?
              smh_pkg::MUL_K[smh_pkg::DATA_W-1:smh_pkg::HALF_W] :
              smh_pkg::MUL_K[smh_pkg::HALF_W-1:0];
      full_prod = smh_pkg::DATA_W'(a_sel) * smh_pkg::DATA_W'(b_sel);
   end

   // partial product stage
   always_comb begin
      a_in      = a_ff;
      busy_in   = busy_ff;
      part_in   = part_ff;
      prod_in   = prod_ff;
      pvld_in   = 1'b0;
      pfirst_in = 1'b0;
      plast_in  = 1'b0;
      if (busy_ff) begin
         pvld_in   = 1'b1;
         pfirst_in = (part_ff == smh_pkg::PART_LL);
         plast_in  = (part_ff == smh_pkg::PART_LH);
         // cross terms only reach the upper half
         prod_in = (part_ff == smh_pkg::PART_LL) ? full_prod
                   : {full_prod[smh_pkg::HALF_W-1:0], {smh_pkg::HALF_W{1'b0}}};
         unique case (part_ff)
            smh_pkg::PART_LL: part_in = smh_pkg::PART_HL;
            smh_pkg::PART_HL: part_in = smh_pkg::PART_LH;
            default: begin
               part_in = smh_pkg::PART_LL;
               busy_in = 1'b0;
            end
         endcase
      end else if (req.go) begin
         a_in    = req.operand;
         busy_in = 1'b1;
         part_in = smh_pkg::PART_LL;
      end
   end

   // accumulate stage
   always_comb begin
      acc_in  = acc_ff;
      done_in = 1'b0;
      if (pvld_ff) begin
         acc_in  = pfirst_ff ? prod_ff : acc_ff + prod_ff;
         done_in = plast_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         part_ff <= smh_pkg::PART_LL;
         pvld_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         part_ff <= part_in;
         pvld_ff <= pvld_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff      <= a_in;
      prod_ff   <= prod_in;
      pfirst_ff <= pfirst_in;
      plast_ff  <= plast_in;
      acc_ff    <= acc_in;
   end

   assign rsp.done    = done_ff;
   assign rsp.product = acc_ff;

endmodule

[rtl/smh_back.sv]
// ----------------------------------------------------------------------------
// smh_back
// Sequencer that carries out queued commands on the running hash and
// holds the response register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module smh_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [smh_pkg::SEED_W-1:0]  seed,
   input  logic                        q_valid,
   input  smh_pkg::cmd_type            q_head,
   output logic                        q_pop,
   output smh_pkg::mul_req_type        mreq,
   input  smh_pkg::mul_rsp_type        mrsp,
   smh_rsp_if.source                   rsp
);

   typedef struct packed {
      smh_pkg::back_state_type    state;
      logic                       go;
      logic [smh_pkg::DATA_W-1:0] opd;
   } step_type;

   smh_pkg::back_state_type    state_ff, state_in;
   smh_pkg::cmd_type           cmd_ff, cmd_in;
   logic [smh_pkg::DATA_W-1:0] hash_ff, hash_in;
   logic                       out_valid_ff, out_valid_in;
   logic [smh_pkg::DATA_W-1:0] out_hash_ff, out_hash_in;
   step_type                   step;
   logic [smh_pkg::DATA_W-1:0] h;
   logic [smh_pkg::DATA_W-1:0] k;

   // after the data: segment finalization, then emission
   function automatic step_type after_data(smh_pkg::cmd_type c,
                                           logic [smh_pkg::DATA_W-1:0] hv);
      step_type s;
      s.state = smh_pkg::ST_IDLE;
      s.go    = 1'b0;
      s.opd   = hv ^ (hv >> smh_pkg::SHIFT_R);
      if (c.fin) begin
         s.state = smh_pkg::ST_FIN;
         s.go    = 1'b1;
      end else if (c.emit) begin
         s.state = smh_pkg::ST_EMIT;
      end
      return s;
   endfunction

   // data step of an item
   function automatic step_type data_step(smh_pkg::cmd_type c,
                                          logic [smh_pkg::DATA_W-1:0] hv);
      step_type s;
      unique case (c.kind)
         smh_pkg::KIND_FULL: begin
            s.state = smh_pkg::ST_KMIX1;
            s.go    = 1'b1;
            s.opd   = c.word;
         end
         smh_pkg::KIND_TAIL: begin
            s.state = smh_pkg::ST_TAIL;
            s.go    = 1'b1;
            s.opd   = hv ^ c.word;
         end
         default: s = after_data(c, hv);
      endcase
      return s;
   endfunction

   // sequencer
   always_comb begin
      cmd_in       = cmd_ff;
      hash_in      = hash_ff;
      q_pop        = 1'b0;
      out_valid_in = out_valid_ff && !rsp.ready;
      out_hash_in  = out_hash_ff;
      step.state   = state_ff;
      step.go      = 1'b0;
      step.opd     = '0;
      h            = '0;
      k            = mrsp.product ^ (mrsp.product >> smh_pkg::SHIFT_R);
      unique case (state_ff)
         smh_pkg::ST_IDLE: begin
            if (q_valid) begin
               q_pop  = 1'b1;
               cmd_in = q_head;
               if (q_head.start) begin
                  step.state = smh_pkg::ST_SEED;
                  step.go    = 1'b1;
                  step.opd   = smh_pkg::DATA_W'(q_head.total);
               end else begin
                  step = data_step(q_head, hash_ff);
               end
            end
         end
         smh_pkg::ST_SEED: begin
            if (mrsp.done) begin
               h       = smh_pkg::DATA_W'(seed) ^ mrsp.product;
               hash_in = h;
               step    = data_step(cmd_ff, h);
            end
         end
         smh_pkg::ST_KMIX1: begin
            if (mrsp.done) begin
               step.state = smh_pkg::ST_KMIX2;
               step.go    = 1'b1;
               step.opd   = k;
            end
         end
         smh_pkg::ST_KMIX2: begin
            if (mrsp.done) begin
               step.state = smh_pkg::ST_HMIX;
               step.go    = 1'b1;
               step.opd   = hash_ff ^ mrsp.product;
            end
         end
         smh_pkg::ST_HMIX, smh_pkg::ST_TAIL: begin
            if (mrsp.done) begin
               hash_in = mrsp.product;
               step    = after_data(cmd_ff, mrsp.product);
            end
         end
         smh_pkg::ST_FIN: begin
            if (mrsp.done) begin
               hash_in    = k;
               step.state = cmd_ff.emit ? smh_pkg::ST_EMIT : smh_pkg::ST_IDLE;
            end
         end
         smh_pkg::ST_EMIT: begin
            // load the response register once it is free
            if (!out_valid_ff || rsp.ready) begin
               out_valid_in = 1'b1;
               out_hash_in  = hash_ff;
               step.state   = smh_pkg::ST_IDLE;
            end
         end
         default: step.state = smh_pkg::ST_IDLE;
      endcase
      state_in = step.state;
   end

   assign mreq.go      = step.go;
   assign mreq.operand = step.opd;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= smh_pkg::ST_IDLE;
         hash_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hash_ff      <= hash_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      out_hash_ff <= out_hash_in;
   end

   assign rsp.valid      = out_valid_ff;
   assign rsp.hash_value = out_hash_ff;

endmodule

[rtl/smh_checker.sv]
// ----------------------------------------------------------------------------
// smh_checker
// Port-level checks of the segmented MurmurHash64A block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "segmented_murmur64a_hash_top_macros.svh"

module smh_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       req_message_end,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [smh_pkg::DATA_W-1:0] rsp_hash_value
);

   // responses owed: accepted message ends not yet transferred out
   logic [3:0] pending_ff, pending_in;

   always_comb begin
      pending_in = pending_ff;
      if (req_valid && req_ready && req_message_end) begin
         pending_in = pending_in + 4'd1;
      end
      if (rsp_valid && rsp_ready) begin
         pending_in = pending_in - 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // no response right after reset
   `SMH_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !rsp_valid)

   // a stalled response holds
   `SMH_ASSERT(a_rsp_hold, clock, reset,
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hash_value))

   // every response is owed to an accepted message end
   `SMH_ASSERT(a_rsp_owed, clock, reset, rsp_valid |-> pending_ff != 4'd0)

   // queue, sequencer and response register bound what can be outstanding
   `SMH_ASSERT(a_pending_cap, clock, reset, pending_ff <= 4'd4)

endmodule

bind segmented_murmur64a_hash_top smh_checker u_smh_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_bus.valid),
   .req_ready       (req_bus.ready),
   .req_message_end (req_bus.message_end),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_hash_value  (rsp_bus.hash_value)
);
